>>> hw/rtl/ddq_pkg.sv
// Shared codes and chain control structs for the double-ended queue engine.
// No dependencies; imported by the cell, the top level and the checker.
`default_nettype none

package ddq_pkg;

  // Request codes
  localparam logic [3:0] OP_PUSH_BACK  = 4'd0;
  localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
  localparam logic [3:0] OP_POP_BACK   = 4'd2;
  localparam logic [3:0] OP_POP_FRONT  = 4'd3;
  localparam logic [3:0] OP_COUNT      = 4'd4;
  localparam logic [3:0] OP_READ       = 4'd5;
  localparam logic [3:0] OP_FRONT      = 4'd6;
  localparam logic [3:0] OP_BACK       = 4'd7;
  localparam logic [3:0] OP_CLEAR      = 4'd8;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADIDX = 2'd3;

  // Saturation point of the 7-bit count fields
  localparam logic [6:0] CNT7_MAX = 7'd127;

  // Per-cycle move command broadcast to every cell
  typedef struct packed {
    logic take_left;   // every cell takes its left neighbor
    logic take_right;  // every cell takes its right neighbor
    logic load_tail;   // the cell at index == count loads the value
  } ddq_shift_t;

  // Scan token that walks the chain one cell per cycle
  typedef struct packed {
    logic       valid;
    logic [6:0] acc;   // saturating match count
  } ddq_tok_t;

endpackage

`default_nettype wire

>>> hw/rtl/ddq_cell.sv
// One element slot of the queue chain, plus one stage of the scan token path.
// Depends on ddq_pkg (ddq_shift_t, ddq_tok_t, CNT7_MAX).
`default_nettype none

module ddq_cell import ddq_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32,
  parameter int IDX        = 0,
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int IW        = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ddq_shift_t            shift,
  input  wire logic [CW-1:0]         cnt,
  input  wire logic [IW-1:0]         target,
  input  wire logic [ELEM_WIDTH-1:0] val,
  input  wire logic [ELEM_WIDTH-1:0] left_elem,
  input  wire logic [ELEM_WIDTH-1:0] right_elem,
  input  wire ddq_tok_t              tok_in,
  input  wire logic [ELEM_WIDTH-1:0] rd_in,
  output logic [ELEM_WIDTH-1:0]      elem,
  output ddq_tok_t                   tok_out,
  output logic [ELEM_WIDTH-1:0]      rd_out
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [IW-1:0] IDX_T = IW'(IDX);

  logic [ELEM_WIDTH-1:0] elem_r, elem_nxt;
  logic                  tok_valid_r;
  logic [6:0]            tok_acc_r, tok_acc_nxt;
  logic [ELEM_WIDTH-1:0] rd_r, rd_nxt;
  logic                  hit;

  always_comb begin
    elem_nxt = elem_r;
    if (shift.take_left) begin
      elem_nxt = left_elem;
    end else if (shift.take_right) begin
      elem_nxt = right_elem;
    end else if (shift.load_tail && (cnt == IDX_C)) begin
      elem_nxt = val;
    end
  end

  // only occupied slots count
  assign hit = (IDX_C < cnt) && (elem_r == val);

  always_comb begin
    tok_acc_nxt = tok_in.acc;
    if (hit && (tok_in.acc != CNT7_MAX)) begin
      tok_acc_nxt = tok_in.acc + 7'd1;
    end
    rd_nxt = (target == IDX_T) ? elem_r : rd_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    elem_r    <= elem_nxt;
    tok_acc_r <= tok_acc_nxt;
    rd_r      <= rd_nxt;
  end

  assign elem          = elem_r;
  assign tok_out.valid = tok_valid_r;
  assign tok_out.acc   = tok_acc_r;
  assign rd_out        = rd_r;

endmodule

`default_nettype wire

>>> hw/rtl/double_ended_queue_engine_top.sv
// Results: registered in the cycle after the input transfer, except count and in-range read index
//   or back, which first walk a token down the chain through all DEPTH cells.
// Throughput: 1 item per cycle for short requests while results drain; a scan request
//   holds off further input until the token has walked all DEPTH cells.
// Reset: synchronous, active low; clears occupancy, control and valid flags, not the
//   stored elements. Depends on ddq_pkg and ddq_cell.
`default_nettype none

module double_ended_queue_engine_top import ddq_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         in_func,
  input  wire logic signed [31:0] in_value,
  input  wire logic [5:0]         in_position,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_read_value,
  output logic [6:0]              out_match_count,
  output logic                    out_found,
  output logic [6:0]              out_occupancy,
  output logic [1:0]              out_status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int EW = ELEM_WIDTH;

  // Two-state controller: idle takes requests, scan waits for the token
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } ddq_state_t;

  ddq_state_t     st_r, st_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           launch_r, launch_nxt;

  // Scan request held while the token runs
  logic           q_is_count_r, q_is_count_nxt;
  logic [IW-1:0]  q_target_r, q_target_nxt;
  logic [EW-1:0]  q_val_r, q_val_nxt;

  // Output register
  logic           out_valid_r;
  logic [31:0]    out_rd_r;
  logic [6:0]     out_match_r;
  logic [6:0]     out_occ_r;
  logic [1:0]     out_status_r;

  // Chain wiring
  ddq_shift_t     shift;
  logic [EW-1:0]  cell_val;
  logic [EW-1:0]  elem    [DEPTH];
  ddq_tok_t       tok     [DEPTH];
  logic [EW-1:0]  rd_chain[DEPTH];
  ddq_tok_t       tok_head;

  // Result being loaded this cycle
  logic           res_load;
  logic [EW-1:0]  res_rd;
  logic [6:0]     res_match;
  logic [6:0]     res_occ;
  logic [1:0]     res_status;

  logic           in_fire;
  logic [EW-1:0]  in_elem;
  logic [EW+31:0] in_ext;
  logic [EW+31:0] rd_ext;
  logic [CW+5:0]  pos_cmp;
  logic [CW+5:0]  cnt_cmp;
  logic [IW+5:0]  pos_ext;
  logic [CW-1:0]  cnt_m1;
  logic [CW+6:0]  occ_ext;
  logic           is_full;
  logic           is_empty;

  // New request only when idle and the output slot is free or draining
  assign in_ready = (st_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // Stored elements are the low ELEM_WIDTH bits of the zero-extended value
  assign in_ext  = {{EW{1'b0}}, in_value};
  assign in_elem = in_ext[EW-1:0];

  assign pos_cmp  = {{CW{1'b0}}, in_position};
  assign cnt_cmp  = {6'b0, cnt_r};
  assign pos_ext  = {{IW{1'b0}}, in_position};
  assign cnt_m1   = cnt_r - CW'(1);
  assign is_full  = (cnt_r == CW'(DEPTH));
  assign is_empty = (cnt_r == '0);

  // Pushes use the live request value; scans use the held one
  assign cell_val = (st_r == S_SCAN) ? q_val_r : in_elem;

  assign tok_head.valid = launch_r;
  assign tok_head.acc   = '0;

  always_comb begin
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    launch_nxt     = 1'b0;
    q_is_count_nxt = q_is_count_r;
    q_target_nxt   = q_target_r;
    q_val_nxt      = q_val_r;
    shift          = '0;
    res_load       = 1'b0;
    res_rd         = '0;
    res_match      = '0;
    res_status     = ST_OK;

    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          res_load = 1'b1;
          unique case (in_func)
            OP_PUSH_BACK: begin
              if (is_full) begin
                res_status = ST_FULL;
              end else begin
                shift.load_tail = 1'b1;
                cnt_nxt         = cnt_r + CW'(1);
              end
            end
            OP_PUSH_FRONT: begin
              if (is_full) begin
                res_status = ST_FULL;
              end else begin
                shift.take_left = 1'b1;
                cnt_nxt         = cnt_r + CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                res_status = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_m1;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                res_status = ST_EMPTY;
              end else begin
                shift.take_right = 1'b1;
                cnt_nxt          = cnt_m1;
              end
            end
            OP_COUNT: begin
              res_load       = 1'b0;
              st_nxt         = S_SCAN;
              launch_nxt     = 1'b1;
              q_is_count_nxt = 1'b1;
              q_target_nxt   = '0;
              q_val_nxt      = in_elem;
            end
            OP_READ: begin
              if (pos_cmp >= cnt_cmp) begin
                res_status = ST_BADIDX;
              end else begin
                res_load       = 1'b0;
                st_nxt         = S_SCAN;
                launch_nxt     = 1'b1;
                q_is_count_nxt = 1'b0;
                q_target_nxt   = pos_ext[IW-1:0];
              end
            end
            OP_FRONT: begin
              if (is_empty) begin
                res_status = ST_EMPTY;
              end else begin
                res_rd = elem[0];
              end
            end
            OP_BACK: begin
              if (is_empty) begin
                res_status = ST_EMPTY;
              end else begin
                res_load       = 1'b0;
                st_nxt         = S_SCAN;
                launch_nxt     = 1'b1;
                q_is_count_nxt = 1'b0;
                q_target_nxt   = cnt_m1[IW-1:0];
              end
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              // unused codes: no operation
            end
          endcase
        end
      end
      S_SCAN: begin
        // token leaving the last cell carries the answer
        if (tok[DEPTH-1].valid) begin
          res_load = 1'b1;
          st_nxt   = S_IDLE;
          if (q_is_count_r) begin
            res_match = tok[DEPTH-1].acc;
          end else begin
            res_rd = rd_chain[DEPTH-1];
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Occupancy after the request, saturated to the 7-bit field
  always_comb begin
    occ_ext = {7'b0, cnt_nxt};
    res_occ = (occ_ext > (CW + 7)'(CNT7_MAX)) ? CNT7_MAX : occ_ext[6:0];
  end

  assign rd_ext = {32'b0, res_rd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      launch_r <= launch_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_is_count_r <= q_is_count_nxt;
    q_target_r   <= q_target_nxt;
    q_val_r      <= q_val_nxt;
    if (res_load) begin
      out_rd_r     <= rd_ext[31:0];
      out_match_r  <= res_match;
      out_occ_r    <= res_occ;
      out_status_r <= res_status;
    end
  end

  // Chain of cells: front element in cell 0, back in cell count-1.
  // Data moves one cell per cycle on front pushes and pops; the scan
  // token moves one cell per cycle from cell 0 to the last cell.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [EW-1:0] left_w;
    logic [EW-1:0] right_w;
    ddq_tok_t      tok_in_w;
    logic [EW-1:0] rd_in_w;

    if (i == 0) begin : g_first
      assign left_w   = cell_val;
      assign tok_in_w = tok_head;
      assign rd_in_w  = '0;
    end else begin : g_mid
      assign left_w   = elem[i-1];
      assign tok_in_w = tok[i-1];
      assign rd_in_w  = rd_chain[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = elem[i];
    end else begin : g_inner
      assign right_w = elem[i+1];
    end

    ddq_cell #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (EW),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift      (shift),
      .cnt        (cnt_r),
      .target     (q_target_r),
      .val        (cell_val),
      .left_elem  (left_w),
      .right_elem (right_w),
      .tok_in     (tok_in_w),
      .rd_in      (rd_in_w),
      .elem       (elem[i]),
      .tok_out    (tok[i]),
      .rd_out     (rd_chain[i])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_rd_r;
  assign out_match_count = out_match_r;
  assign out_found       = (out_match_r != 7'd0);
  assign out_occupancy   = out_occ_r;
  assign out_status      = out_status_r;

endmodule

`default_nettype wire

>>> hw/rtl/ddq_checker.sv
// Port-level checks for the double-ended queue engine, bound to the top level.
// Depends on ddq_pkg status codes and the top level's port names.
`default_nettype none

module ddq_checker import ddq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic signed [31:0] out_read_value,
  input wire logic [6:0]         out_match_count,
  input wire logic               out_found,
  input wire logic [6:0]         out_occupancy,
  input wire logic [1:0]         out_status
);

  localparam logic [6:0] OCC_CAP = (DEPTH > 127) ? 7'd127 : 7'(DEPTH);

  a_found_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found == (out_match_count != 7'd0)))
    else $error("found disagrees with match count");

  a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= OCC_CAP))
    else $error("occupancy beyond depth");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_occupancy == OCC_CAP))
    else $error("dropped push while not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |-> (out_occupancy == 7'd0))
    else $error("empty status with elements held");

  a_err_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      ((out_read_value == 32'sd0) && (out_match_count == 7'd0)))
    else $error("failed request returned data");

endmodule

bind double_ended_queue_engine_top ddq_checker #(.DEPTH(DEPTH)) u_ddq_checker (.*);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking bench for double_ended_queue_engine_top: random and directed deque requests.
// A queued driver, a stalling result receiver and an in-order deque predictor.
// Depends on ddq_pkg and the engine RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ddq_pkg::*;

  localparam int DEPTH            = 64;
  localparam int RANDOM_ITEMS     = 1425;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int LONG_HOLD_AT     = 300;   // transfers in before the long result stall
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES      = 4 * DEPTH;
  localparam int MAX_REPORTS      = 10;

  // func codes the block treats as no-ops
  localparam logic [3:0] OP_NOP_FIRST = OP_CLEAR + 4'd1;
  localparam logic [3:0] OP_NOP_LAST  = 4'hF;

  // request mixes of the random phases
  localparam int PHASE_FILL  = 0;
  localparam int PHASE_DRAIN = 1;
  localparam int PHASE_MIXED = 2;

  typedef struct {
    logic [3:0]         func;
    logic signed [31:0] value;
    logic [5:0]         position;
    bit                 drain_before;  // sender waits until every result is back
  } deq_request_t;

  typedef struct {
    logic signed [31:0] read_value;
    logic [6:0]         match_count;
    logic               found;
    logic [6:0]         occupancy;
    logic [1:0]         status;
  } deq_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         in_func = OP_PUSH_BACK;
  logic signed [31:0] in_value = '0;
  logic [5:0]         in_position = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_read_value;
  logic [6:0]         out_match_count;
  logic               out_found;
  logic [6:0]         out_occupancy;
  logic [1:0]         out_status;

  double_ended_queue_engine_top #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (32)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_match_count (out_match_count),
    .out_found       (out_found),
    .out_occupancy   (out_occupancy),
    .out_status      (out_status)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Deque predictor: own copy of the ring, head and occupancy
  // ---------------------------------------------------------------------------
  logic signed [31:0] ring_mem [DEPTH];
  logic [5:0]         ring_head  = '0;
  logic [6:0]         ring_count = '0;

  function automatic deq_result_t deque_apply(logic [3:0] func, logic signed [31:0] value,
                                              logic [5:0] position);
    deq_result_t r;
    logic [5:0]  slot;
    r = '{default: '0};
    case (func)
      OP_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = ring_head + ring_count[5:0];
          ring_mem[slot] = value;
          ring_count++;
        end
      end
      OP_PUSH_FRONT: begin
        // also covers the empty case: head moves back one and tail follows
        if (ring_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_head = ring_head - 6'd1;
          ring_mem[ring_head] = value;
          ring_count++;
        end
      end
      OP_POP_BACK: begin
        if (ring_count == 0) r.status = ST_EMPTY;
        else ring_count--;
      end
      OP_POP_FRONT: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          ring_head = ring_head + 6'd1;
          ring_count--;
        end
      end
      OP_COUNT: begin
        for (int i = 0; i < ring_count; i++) begin
          slot = ring_head + 6'(i);
          if (ring_mem[slot] == value) r.match_count++;
        end
        r.found = (r.match_count != 0);
      end
      OP_READ: begin
        if (position >= ring_count) r.status = ST_BADIDX;
        else r.read_value = ring_mem[6'(ring_head + position)];
      end
      OP_FRONT: begin
        if (ring_count == 0) r.status = ST_EMPTY;
        else r.read_value = ring_mem[ring_head];
      end
      OP_BACK: begin
        if (ring_count == 0) r.status = ST_EMPTY;
        else r.read_value = ring_mem[6'(ring_head + ring_count[5:0] - 6'd1)];
      end
      OP_CLEAR: begin
        ring_count = '0;
        ring_head  = '0;
      end
      default: ;
    endcase
    r.occupancy = ring_count;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  deq_request_t requests_to_send [$];
  deq_result_t  deque_results_due [$];
  int           err_count      = 0;
  int           requests_taken = 0;
  int           results_seen   = 0;
  int           cycle_count    = 0;
  bit           req_taken      = 1'b0;  // input transfer at the last rising edge

  task automatic note_failure(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // periodic windows with no idling at all; offset staggers the two sides
  function automatic bit calm_window(int offset);
    return ((cycle_count + offset) % 2500) < 400;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation. Occupancy is tracked here so that reads mostly land
  // inside the queue and fill/drain phases actually hit full and empty.
  // ---------------------------------------------------------------------------
  int gen_occ = 0;
  logic signed [31:0] value_pool [8] = '{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 32'sd0,
                                         32'sd1, 32'sd5, 32'sh1234_5678, -32'sd77};

  task automatic add_req(logic [3:0] func, logic signed [31:0] value, logic [5:0] position,
                         bit drain_before = 1'b0);
    deq_request_t req;
    req.func         = func;
    req.value        = value;
    req.position     = position;
    req.drain_before = drain_before;
    requests_to_send = {requests_to_send, req};
    case (func)
      OP_PUSH_BACK, OP_PUSH_FRONT: if (gen_occ < DEPTH) gen_occ++;
      OP_POP_BACK, OP_POP_FRONT:   if (gen_occ > 0) gen_occ--;
      OP_CLEAR:                    gen_occ = 0;
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_value();
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [5:0] rand_position();
    if (gen_occ > 0 && $urandom_range(0, 3) != 0) return 6'($urandom_range(0, gen_occ - 1));
    return 6'($urandom_range(0, DEPTH - 1));
  endfunction

  function automatic logic [3:0] rand_func(int phase);
    int roll;
    roll = $urandom_range(0, 99);
    if (phase == PHASE_FILL && roll < 70)
      return (roll < 35) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (phase == PHASE_DRAIN && roll < 70)
      return (roll < 35) ? OP_POP_BACK : OP_POP_FRONT;
    roll = $urandom_range(0, 99);
    if (roll < 2) return 4'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
    if (roll < 5) return OP_CLEAR;
    return 4'($urandom_range(OP_PUSH_BACK, OP_BACK));
  endfunction

  task automatic build_stimulus();
    int n_random;
    int phase;
    int len;
    bit same_fill_done;
    logic signed [31:0] v;
    n_random       = 0;
    same_fill_done = 1'b0;

    // directed: every pop, peek, read and count request on an empty queue first
    add_req(OP_POP_BACK,  32'sd0, 6'd0);
    add_req(OP_POP_FRONT, 32'sd0, 6'd0);
    add_req(OP_FRONT,     32'sd0, 6'd0);
    add_req(OP_BACK,      32'sd0, 6'd0);
    add_req(OP_READ,      32'sd0, 6'd0);
    add_req(OP_COUNT,     32'sd0, 6'd0);
    // push to front while empty must set the tail too
    add_req(OP_PUSH_FRONT, 32'sh8000_0000, 6'd0);
    add_req(OP_BACK,       32'sd0, 6'd0);
    add_req(OP_PUSH_BACK,  32'sh7FFF_FFFF, 6'd0);
    add_req(OP_PUSH_BACK,  -32'sd1, 6'd0);
    add_req(OP_PUSH_FRONT, 32'sd0, 6'd63);
    add_req(OP_FRONT,      32'sd0, 6'd0);
    add_req(OP_BACK,       32'sd0, 6'd0);
    add_req(OP_READ,       32'sd0, 6'd3);
    add_req(OP_READ,       32'sd0, 6'd4);
    add_req(OP_READ,       32'sd0, 6'd63);
    add_req(OP_COUNT,      -32'sd1, 6'd0);
    add_req(OP_NOP_FIRST,  -32'sd1, 6'd63);
    add_req(OP_NOP_LAST,   32'sh5555_AAAA, 6'd42);
    add_req(OP_POP_BACK,   32'sd0, 6'd0);
    add_req(OP_POP_FRONT,  32'sd0, 6'd0);
    add_req(OP_CLEAR,      32'sd0, 6'd0);
    add_req(OP_COUNT,      32'sd0, 6'd0);

    while (n_random < RANDOM_ITEMS) begin
      if (!same_fill_done && n_random > 500) begin
        // queue filled with one value: count hits the full depth, pushes drop
        same_fill_done = 1'b1;
        v = rand_value();
        add_req(OP_CLEAR, 32'sd0, 6'd0, 1'b1);
        for (int i = 0; i < DEPTH; i++)
          add_req(($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT, v, 6'd0);
        add_req(OP_COUNT,      v, 6'd0);
        add_req(OP_PUSH_BACK,  ~v, 6'd0);
        add_req(OP_PUSH_FRONT, ~v, 6'd0);
        add_req(OP_READ,       32'sd0, 6'd63);
        add_req(OP_BACK,       32'sd0, 6'd0);
        add_req(OP_COUNT,      ~v, 6'd0);
        add_req(OP_POP_FRONT,  32'sd0, 6'd0);
        add_req(OP_PUSH_BACK,  ~v, 6'd0);
        add_req(OP_COUNT,      v, 6'd0);
        n_random += DEPTH + 9;
      end
      phase = $urandom_range(PHASE_FILL, PHASE_MIXED);
      len   = $urandom_range(20, 80);
      for (int k = 0; k < len && n_random < RANDOM_ITEMS; k++) begin
        logic [3:0] f;
        f = rand_func(phase);
        add_req(f, rand_value(), rand_position(), (n_random % 350) == 0);
        n_random++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Rising edge: record the input transfer into the predictor, then check any
  // result transfer against the oldest prediction. Everything here sees the
  // values the block settled on during the previous half period.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    deq_result_t want;
    deq_result_t got;
    deq_result_t pred;
    cycle_count++;
    if (!rst_n) begin
      req_taken = 1'b0;
    end else begin
      req_taken = in_valid && in_ready;
      if (req_taken) begin
        pred = deque_apply(in_func, in_value, in_position);
        deque_results_due = {deque_results_due, pred};
        requests_taken++;
      end
      if (out_valid && out_ready) begin
        got = '{out_read_value, out_match_count, out_found, out_occupancy, out_status};
        results_seen++;
        if (deque_results_due.size() == 0) begin
          note_failure($sformatf("result %0d arrived with no request outstanding",
                                 results_seen));
        end else begin
          want = deque_results_due[0];
          deque_results_due.delete(0);
          if (got.read_value !== want.read_value || got.match_count !== want.match_count ||
              got.found !== want.found || got.occupancy !== want.occupancy ||
              got.status !== want.status)
            note_failure($sformatf(
              {"result %0d mismatch: exp rv=%0d mc=%0d f=%0b occ=%0d st=%0d,",
               " got rv=%0d mc=%0d f=%0b occ=%0d st=%0d"},
              results_seen, want.read_value, want.match_count, want.found, want.occupancy,
              want.status, got.read_value, got.match_count, got.found, got.occupancy,
              got.status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver, falling edge. A request stays on the bus unchanged until
  // its transfer; drain-marked requests wait until every result is back.
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(negedge clk) begin
    deq_request_t item;
    if (rst_n && !(in_valid && !req_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (requests_to_send.size() != 0 &&
                   !(requests_to_send[0].drain_before && deque_results_due.size() != 0)) begin
        item = requests_to_send[0];
        requests_to_send.delete(0);
        in_func     <= item.func;
        in_value    <= item.value;
        in_position <= item.position;
        in_valid    <= 1'b1;
        send_gap = calm_window(0) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver, falling edge. Random stalls, plus one long hold so the
  // engine backs up and stalls its request channel while the driver keeps going.
  // ---------------------------------------------------------------------------
  int  rx_hold        = 0;
  bit  long_hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && requests_taken >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        rx_hold = LONG_HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (calm_window(1250)) begin
        out_ready <= 1'b1;
      end else begin
        rx_hold = pick_gap();
        out_ready <= (rx_hold == 0);
        if (rx_hold > 0) rx_hold--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // all requests sent and every result back
    while (requests_to_send.size() != 0 || in_valid || deque_results_due.size() != 0)
      @(posedge clk);
    // let any stray result surface
    repeat (TAIL_CYCLES) @(posedge clk);
    if (deque_results_due.size() != 0)
      note_failure($sformatf("%0d results never arrived", deque_results_due.size()));
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ddq_pkg.sv
hw/rtl/ddq_cell.sv
hw/rtl/double_ended_queue_engine_top.sv
hw/rtl/ddq_checker.sv
tb/sv/tb.sv
